FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Implication checks on a clock, reset-qualified; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: design/lpcf_pkg.sv
// ----------------------------------------------------------------------------
// lpcf_pkg
// Shared widths, register codes and control types of the peak clipping filter.
// ----------------------------------------------------------------------------
package lpcf_pkg;

  localparam int PIX_OUT_W  = 32;
  localparam int ROWS_W     = 16;
  localparam int COLS_CFG_W = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SLOT_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd1;

  typedef struct packed {
    logic load_centre;
    logic merge;
    logic merge_en;
    logic finish;
  } unit_ctl_t;

endpackage

FILE: design/lpcf_ram.sv
// ----------------------------------------------------------------------------
// lpcf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpcf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 96
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/lpcf_max_unit.sv
// ----------------------------------------------------------------------------
// lpcf_max_unit
// Shared compare unit: tracks the neighbour maximum, then clips the centre.
// ----------------------------------------------------------------------------
module lpcf_max_unit
  import lpcf_pkg::*;
#(
  parameter int PIXEL_WIDTH = 32
) (
  input  logic                   clk,
  input  unit_ctl_t              ctl,
  input  logic [PIXEL_WIDTH-1:0] rd_data,
  output logic [PIXEL_WIDTH-1:0] result
);

  logic [PIXEL_WIDTH-1:0] centre;
  logic [PIXEL_WIDTH-1:0] best;
  logic [PIXEL_WIDTH-1:0] operand;
  logic                   gt;

  assign operand = ctl.finish ? centre : rd_data;
  assign gt      = operand > best;
  assign result  = best;

  always_ff @(posedge clk) begin
    if (ctl.load_centre) begin
      centre <= rd_data;
      best   <= '0;
    end else if (ctl.merge) begin
      if (ctl.merge_en && gt) begin
        best <= rd_data;
      end
    end else if (ctl.finish) begin
      if (!gt) begin
        best <= centre;
      end
    end
  end

endmodule

FILE: design/local_peak_clipping_filter_core.sv
// ----------------------------------------------------------------------------
// local_peak_clipping_filter_core
// Four-neighbour peak clipping over a raster frame, one line-store pass.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ stream in raster order; clipped pixels leave on the
// m_ stream one row late, with m_tuser marking the end of a row and m_tlast
// the end of the frame. The last input pixel of a frame flushes the whole
// last row. Frame size is set through cfg_we / cfg_index / cfg_data; any
// register write restarts the frame.
// Each output pixel needs five reads of the three-row line store (centre,
// up, down, left, right) through its single read port, then one clip step
// on the shared compare unit: an input item that produces a result holds
// s_tready low until its result is loaded into the output register; items
// of the first row do not. The frame's last item holds it through the flush.
// The result sits in an output register; while the receiver stalls, the
// block waits with the next result and accepts no input. Reset clears the
// frame position and sets both size registers to 1; the line store needs no
// clearing, since every entry is written in a frame before it is read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module local_peak_clipping_filter_core
  import lpcf_pkg::*;
#(
  parameter int MAX_COLS    = 32,
  parameter int PIXEL_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [PIX_OUT_W-1:0]  s_tdata,   // pixel_in
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [PIX_OUT_W-1:0]  m_tdata,   // pixel_out
  output logic                  m_tuser,   // row_end
  output logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int DEPTH = 3 * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] BASE1 = AW'(MAX_COLS);
  localparam logic [AW-1:0] BASE2 = AW'(2 * MAX_COLS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  localparam logic [2:0] STEP_CENTRE = 3'd0;
  localparam logic [2:0] STEP_UP     = 3'd1;
  localparam logic [2:0] STEP_DOWN   = 3'd2;
  localparam logic [2:0] STEP_LEFT   = 3'd3;
  localparam logic [2:0] STEP_RIGHT  = 3'd4;
  localparam logic [2:0] STEP_DONE   = 3'd5;

  logic [ROWS_W-1:0] rows;
  logic [CW-1:0]     cols;
  logic [ROWS_W-1:0] row_index;
  logic [CW-1:0]     col_index;
  logic [SLOT_W-1:0] slot_cur, slot_prev, slot_prev2;

  logic [1:0] state;
  logic [2:0] step;

  logic [SLOT_W-1:0] j_cur, j_prev, j_prev2;
  logic [CW-1:0]     j_col;
  logic              j_r_gt0, j_r_gt1, j_last;
  logic              flushing;
  logic [CW-1:0]     flush_j;

  logic                   accept;
  logic                   wrap;
  logic [ROWS_W-1:0]      r_e;
  logic [CW-1:0]          c_e;
  logic [SLOT_W-1:0]      s_e;
  logic                   is_last;
  logic                   row_done;
  logic [SLOT_W-1:0]      s_rot;

  logic [SLOT_W-1:0]      t_slot, u_slot, d_slot, rd_slot;
  logic [CW-1:0]          t_col, rd_col;
  logic                   has_up, has_dn, t_rend, t_fend;
  logic                   left_ok, right_ok;
  logic                   prev_valid;
  logic                   load_out;
  logic                   last_col_t;

  logic [PIXEL_WIDTH-1:0] rd_data;
  logic [PIXEL_WIDTH-1:0] result;
  logic [AW-1:0]          waddr, raddr;
  unit_ctl_t              ctl;

  function automatic logic [AW-1:0] addr_of(input logic [SLOT_W-1:0] slot,
                                            input logic [CW-1:0] col);
    logic [AW-1:0] base;
    unique case (slot)
      2'd1:    base = BASE1;
      2'd2:    base = BASE2;
      default: base = '0;
    endcase
    return base + AW'(col);
  endfunction

  // frame position
  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign wrap     = (col_index >= cols) || (row_index >= rows);
  assign r_e      = wrap ? '0 : row_index;
  assign c_e      = wrap ? '0 : col_index;
  assign s_e      = wrap ? '0 : slot_cur;
  assign row_done = (c_e == cols - CW'(1));
  assign is_last  = row_done && (r_e == rows - ROWS_W'(1));
  assign s_rot    = (s_e == SLOT_W'(2)) ? '0 : s_e + SLOT_W'(1);
  assign waddr    = addr_of(s_e, c_e);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows       <= ROWS_W'(1);
      cols       <= CW'(1);
      row_index  <= '0;
      col_index  <= '0;
      slot_cur   <= '0;
      slot_prev  <= SLOT_W'(2);
      slot_prev2 <= SLOT_W'(1);
    end else if (cfg_we && (cfg_index == REG_FRAME_ROWS || cfg_index == REG_FRAME_COLS))
    begin
      if (cfg_index == REG_FRAME_ROWS) begin
        rows <= (cfg_data == '0) ? ROWS_W'(1) : cfg_data;
      end else if (cfg_data[COLS_CFG_W-1:0] == '0) begin
        cols <= CW'(1);
      end else if (cfg_data[COLS_CFG_W-1:0] > COLS_CFG_W'(MAX_COLS)) begin
        cols <= CW'(MAX_COLS);
      end else begin
        cols <= CW'(cfg_data[COLS_CFG_W-1:0]);
      end
      row_index  <= '0;
      col_index  <= '0;
      slot_cur   <= '0;
      slot_prev  <= SLOT_W'(2);
      slot_prev2 <= SLOT_W'(1);
    end else if (accept) begin
      if (is_last) begin
        row_index  <= '0;
        col_index  <= '0;
        slot_cur   <= '0;
        slot_prev  <= SLOT_W'(2);
        slot_prev2 <= SLOT_W'(1);
      end else if (row_done) begin
        row_index  <= r_e + ROWS_W'(1);
        col_index  <= '0;
        slot_cur   <= s_rot;
        slot_prev  <= s_e;
        slot_prev2 <= wrap ? SLOT_W'(2) : slot_prev;
      end else begin
        row_index <= r_e;
        col_index <= c_e + CW'(1);
        slot_cur  <= s_e;
        if (wrap) begin
          slot_prev  <= SLOT_W'(2);
          slot_prev2 <= SLOT_W'(1);
        end
      end
    end
  end

  // target pixel of the current job
  assign t_slot     = flushing ? j_cur   : j_prev;
  assign u_slot     = flushing ? j_prev  : j_prev2;
  assign d_slot     = j_cur;
  assign t_col      = flushing ? flush_j : j_col;
  assign has_up     = flushing ? j_r_gt0 : j_r_gt1;
  assign has_dn     = !flushing;
  assign last_col_t = (t_col == cols - CW'(1));
  assign left_ok    = (t_col != '0);
  assign right_ok   = !last_col_t;
  assign t_rend     = last_col_t;
  assign t_fend     = flushing && last_col_t;

  always_comb begin
    rd_slot = t_slot;
    rd_col  = t_col;
    case (step)
      STEP_UP:    rd_slot = u_slot;
      STEP_DOWN:  rd_slot = d_slot;
      STEP_LEFT:  rd_col  = left_ok ? t_col - CW'(1) : t_col;
      STEP_RIGHT: rd_col  = right_ok ? t_col + CW'(1) : t_col;
      default:    rd_slot = t_slot;
    endcase
  end

  assign raddr = addr_of(rd_slot, rd_col);

  always_comb begin
    case (step)
      STEP_DOWN:  prev_valid = has_up;
      STEP_LEFT:  prev_valid = has_dn;
      STEP_RIGHT: prev_valid = left_ok;
      STEP_DONE:  prev_valid = right_ok;
      default:    prev_valid = 1'b0;
    endcase
  end

  always_comb begin
    ctl             = '0;
    ctl.load_centre = (state == ST_READ) && (step == STEP_UP);
    ctl.merge       = (state == ST_READ) && (step > STEP_UP);
    ctl.merge_en    = prev_valid;
    ctl.finish      = (state == ST_FINAL);
  end

  lpcf_ram #(
    .WIDTH(PIXEL_WIDTH),
    .DEPTH(DEPTH)
  ) u_row_store (
    .clk  (clk),
    .we   (accept),
    .waddr(waddr),
    .wdata(PIXEL_WIDTH'(s_tdata)),
    .raddr(raddr),
    .rdata(rd_data)
  );

  lpcf_max_unit #(
    .PIXEL_WIDTH(PIXEL_WIDTH)
  ) u_max_unit (
    .clk    (clk),
    .ctl    (ctl),
    .rd_data(rd_data),
    .result (result)
  );

  // sequencer
  assign load_out = (state == ST_EMIT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step     <= STEP_CENTRE;
      flushing <= 1'b0;
      flush_j  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            flushing <= (r_e == '0) && is_last;
            flush_j  <= '0;
            step     <= STEP_CENTRE;
            if ((r_e != '0) || is_last) begin
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          if (step == STEP_DONE) begin
            state <= ST_FINAL;
          end else begin
            step <= step + 3'd1;
          end
        end
        ST_FINAL: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (load_out) begin
            step <= STEP_CENTRE;
            if (!flushing) begin
              if (j_last) begin
                flushing <= 1'b1;
                flush_j  <= '0;
                state    <= ST_READ;
              end else begin
                state <= ST_IDLE;
              end
            end else if (last_col_t) begin
              flushing <= 1'b0;
              state    <= ST_IDLE;
            end else begin
              flush_j <= flush_j + CW'(1);
              state   <= ST_READ;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      j_cur   <= s_e;
      j_prev  <= slot_prev;
      j_prev2 <= slot_prev2;
      j_col   <= c_e;
      j_r_gt0 <= (r_e != '0);
      j_r_gt1 <= (r_e > ROWS_W'(1));
      j_last  <= is_last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= PIX_OUT_W'(result);
      m_tuser <= t_rend;
      m_tlast <= t_fend;
    end
  end

  `ASSERT_NEXT(a_frame_end_idles, clk, rst, load_out && t_fend, state == ST_IDLE)
  `ASSERT_NEXT(a_accept_starts_job, clk, rst, accept && ((r_e != '0) || is_last),
               state == ST_READ)
  `ASSERT_SAME(a_flush_in_row, clk, rst, flushing, flush_j < cols)

endmodule
